// File: sv/aua_pkg.sv
// Shared types and constants for the access unit assembler.
`timescale 1ns / 1ps
package aua_pkg;

    localparam int ZERO_HOLD  = 56;
    localparam int ZR_W       = $clog2(ZERO_HOLD + 1);
    localparam int BYTE_W     = 8;
    localparam int TYPE_W     = 5;
    localparam int FIELD_BITS = BYTE_W + 3;
    localparam int TDATA_W    = ((FIELD_BITS + 7) / 8) * 8;
    localparam int PAD_W      = TDATA_W - FIELD_BITS;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h01;
    localparam logic [BYTE_W-1:0] DROP_RESET = 8'hFF;
    localparam logic [TYPE_W-1:0] NAL_IDR    = 5'd5;
    localparam logic [TYPE_W-1:0] NAL_AUD    = 5'd9;
    localparam logic [1:0]        PFX_LAST   = 2'd3;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOU  = 1'b1;

    typedef enum logic [1:0] {
        MODE_SEARCH,
        MODE_START,
        MODE_EMIT,
        MODE_DROP
    } mode_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_EOU,
        SEQ_PFX,
        SEQ_ZERO,
        SEQ_DATA
    } seq_state_t;

    typedef enum logic [1:0] {
        ZC_HOLD,
        ZC_INC,
        ZC_DEC,
        ZC_CLR
    } zc_op_t;

    typedef struct packed {
        logic zero;
        logic one;
        logic ge2;
        logic full;
    } zc_status_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] out_byte;
        logic              nal_first;
        logic              unit_keyframe;
        logic              zero_overflow;
        logic              last;
    } result_t;

endpackage

// File: sv/aua_zero_ctr.sv
// Held zero run counter: saturating count up, count down on replay, clear.
`timescale 1ns / 1ps
module aua_zero_ctr (
    input  logic              aclk,
    input  logic              aresetn,
    input  aua_pkg::zc_op_t   op,
    output aua_pkg::zc_status_t status
);
    import aua_pkg::*;

    logic [ZR_W-1:0] zr_reg;
    logic [ZR_W-1:0] zr_next;

    always_comb begin
        zr_next = zr_reg;
        unique case (op)
            ZC_HOLD: zr_next = zr_reg;
            ZC_INC: begin
                if (zr_reg != ZR_W'(ZERO_HOLD)) begin
                    zr_next = zr_reg + ZR_W'(1);
                end
            end
            ZC_DEC: begin
                if (zr_reg != '0) begin
                    zr_next = zr_reg - ZR_W'(1);
                end
            end
            ZC_CLR: zr_next = '0;
            default: zr_next = zr_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zr_reg <= '0;
        end else begin
            zr_reg <= zr_next;
        end
    end

    assign status.zero = (zr_reg == '0);
    assign status.one  = (zr_reg == ZR_W'(1));
    assign status.ge2  = (zr_reg >= ZR_W'(2));
    assign status.full = (zr_reg == ZR_W'(ZERO_HOLD));

endmodule

// File: sv/aua_seq.sv
// Parse state and result sequencer: decode one byte, then step out its results.
`timescale 1ns / 1ps
module aua_seq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [aua_pkg::BYTE_W-1:0]  in_byte,
    input  logic [aua_pkg::BYTE_W-1:0]  drop_value,
    input  logic                        take,
    output logic                        res_valid,
    output aua_pkg::result_t            res,
    output aua_pkg::zc_op_t             zc_op,
    input  aua_pkg::zc_status_t         zc_status
);
    import aua_pkg::*;

    seq_state_t        state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [1:0]        pfx_idx_reg, pfx_idx_next;
    logic              key_snap_reg, key_snap_next;
    logic              ovf_rpt_reg, ovf_rpt_next;
    logic              unit_open_reg, unit_open_next;
    logic              unit_key_reg, unit_key_next;
    logic              ovf_seen_reg, ovf_seen_next;

    logic              accept;
    logic              in_zero;
    logic              in_start;
    logic              in_skip;
    logic [BYTE_W-1:0] head;
    logic [TYPE_W-1:0] head_type;
    logic              in_dropnal;
    logic              open_eou;

    assign accept     = in_valid && (state_reg == SEQ_IDLE);
    assign in_zero    = (in_byte == '0);
    assign in_start   = (in_byte == START_BYTE) && zc_status.ge2;
    assign in_skip    = (mode_reg == MODE_SEARCH) || (mode_reg == MODE_DROP);
    // held zeros ahead of the first byte make the header byte 00
    assign head       = zc_status.zero ? in_byte : '0;
    assign head_type  = head[TYPE_W-1:0];
    assign in_dropnal = (mode_reg == MODE_START) && (head == drop_value);
    assign open_eou   = (head_type == NAL_AUD) && unit_open_reg;

    // next state
    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        byte_next      = byte_reg;
        pfx_idx_next   = pfx_idx_reg;
        key_snap_next  = key_snap_reg;
        ovf_rpt_next   = ovf_rpt_reg;
        unit_open_next = unit_open_reg;
        unit_key_next  = unit_key_reg;
        ovf_seen_next  = ovf_seen_reg;
        unique case (state_reg)
            SEQ_IDLE: begin
                if (accept) begin
                    priority if (in_zero) begin
                        if (zc_status.full &&
                            (mode_reg == MODE_START || mode_reg == MODE_EMIT)) begin
                            ovf_seen_next = 1'b1;
                        end
                    end else if (in_start) begin
                        mode_next = MODE_START;
                    end else if (in_skip) begin
                        mode_next = mode_reg;
                    end else if (mode_reg == MODE_EMIT) begin
                        byte_next     = in_byte;
                        ovf_rpt_next  = ovf_seen_reg;
                        ovf_seen_next = 1'b0;
                        state_next    = zc_status.zero ? SEQ_DATA : SEQ_ZERO;
                    end else if (in_dropnal) begin
                        mode_next = MODE_DROP;
                    end else begin
                        byte_next      = in_byte;
                        ovf_rpt_next   = ovf_seen_reg;
                        ovf_seen_next  = 1'b0;
                        key_snap_next  = unit_key_reg;
                        pfx_idx_next   = '0;
                        unit_open_next = 1'b1;
                        mode_next      = MODE_EMIT;
                        if (open_eou) begin
                            unit_key_next = 1'b0;
                        end
                        if (head_type == NAL_IDR) begin
                            unit_key_next = 1'b1;
                        end
                        state_next = open_eou ? SEQ_EOU : SEQ_PFX;
                    end
                end
            end
            SEQ_EOU: begin
                if (take) begin
                    state_next = SEQ_PFX;
                end
            end
            SEQ_PFX: begin
                if (take) begin
                    if (pfx_idx_reg == PFX_LAST) begin
                        state_next = zc_status.zero ? SEQ_DATA : SEQ_ZERO;
                    end else begin
                        pfx_idx_next = pfx_idx_reg + 2'd1;
                    end
                end
            end
            SEQ_ZERO: begin
                if (take && zc_status.one) begin
                    state_next = SEQ_DATA;
                end
            end
            SEQ_DATA: begin
                if (take) begin
                    state_next = SEQ_IDLE;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready          = (state_reg == SEQ_IDLE);
        res_valid         = (state_reg != SEQ_IDLE);
        res.kind          = KIND_DATA;
        res.out_byte      = '0;
        res.nal_first     = 1'b0;
        res.unit_keyframe = 1'b0;
        res.zero_overflow = ovf_rpt_reg;
        res.last          = 1'b0;
        zc_op             = ZC_HOLD;
        unique case (state_reg)
            SEQ_IDLE: begin
                if (accept) begin
                    priority if (in_zero) begin
                        zc_op = ZC_INC;
                    end else if (in_start || in_skip || in_dropnal) begin
                        zc_op = ZC_CLR;
                    end else begin
                        zc_op = ZC_HOLD;
                    end
                end
            end
            SEQ_EOU: begin
                res.kind          = KIND_EOU;
                res.unit_keyframe = key_snap_reg;
            end
            SEQ_PFX: begin
                res.nal_first = (pfx_idx_reg == '0);
                res.out_byte  = (pfx_idx_reg == PFX_LAST) ? START_BYTE : '0;
            end
            SEQ_ZERO: begin
                if (take) begin
                    zc_op = ZC_DEC;
                end
            end
            SEQ_DATA: begin
                res.out_byte = byte_reg;
                res.last     = 1'b1;
            end
            default: res_valid = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= SEQ_IDLE;
            mode_reg      <= MODE_SEARCH;
            pfx_idx_reg   <= '0;
            unit_open_reg <= 1'b0;
            unit_key_reg  <= 1'b0;
            ovf_seen_reg  <= 1'b0;
            ovf_rpt_reg   <= 1'b0;
            key_snap_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            pfx_idx_reg   <= pfx_idx_next;
            unit_open_reg <= unit_open_next;
            unit_key_reg  <= unit_key_next;
            ovf_seen_reg  <= ovf_seen_next;
            ovf_rpt_reg   <= ovf_rpt_next;
            key_snap_reg  <= key_snap_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

endmodule

// File: sv/h264_access_unit_assembler_top.sv
// Top level of the H.264 Annex B access unit assembler.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: in_byte
//  m_      | out | m_tvalid/m_tready  | m_tdata: out_byte, nal_first, unit_keyframe,
//          |     |                    |   zero_overflow; m_tuser: kind; m_tlast: last
//  cfg_    | in  | cfg_wr_en          | cfg_wr_data: drop_header_value
//
// A byte that yields no result only updates the parse state. A byte that yields N words
// is decoded first, then the sequencer steps out one word per cycle while m_tready does
// not stall it; its held zero counter is stepped down once per replayed zero. The worst
// case is an end marker, the four prefix bytes, up to 56 held zeros and the byte.
// s_tready is low while the sequencer is replaying. A stall on m_tready holds the
// output register and freezes the sequencer; reset is synchronous, active low.
`timescale 1ns / 1ps
module h264_access_unit_assembler_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [aua_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] in_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [aua_pkg::TDATA_W-1:0]  m_tdata,   // [7:0] out_byte, [8] nal_first,
                                                    // [9] unit_keyframe,
                                                    // [10] zero_overflow, rest zero
    output logic                         m_tuser,   // [0] kind
    output logic                         m_tlast,   // last word for this input byte
    input  logic                         cfg_wr_en,
    input  logic [aua_pkg::BYTE_W-1:0]   cfg_wr_data
);
    import aua_pkg::*;

    logic [BYTE_W-1:0] drop_reg;
    logic              m_valid_reg, m_valid_next;
    result_t           res_reg, res_next;

    logic              take;
    logic              res_valid;
    result_t           res;
    zc_op_t            zc_op;
    zc_status_t        zc_status;

    // advance the sequencer whenever the output register is free or draining
    assign take = !m_valid_reg || m_tready;

    aua_zero_ctr u_zero_ctr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (zc_op),
        .status  (zc_status)
    );

    aua_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .drop_value (drop_reg),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res),
        .zc_op      (zc_op),
        .zc_status  (zc_status)
    );

    // output register: load a new word when free, otherwise hold
    always_comb begin
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        if (take) begin
            m_valid_next = res_valid;
            res_next     = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            drop_reg    <= DROP_RESET;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                drop_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, res_reg.zero_overflow, res_reg.unit_keyframe,
                       res_reg.nal_first, res_reg.out_byte};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;

endmodule
